[hw/rtl/assert_macros.svh]
// Assertion macros used by mb5_core; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

// Plain invariant.
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

`endif

[hw/rtl/mb5_pkg.sv]
// Shared types and constants of the degree-5 multibrot escape-time unit.
package mb5_pkg;

	localparam int FRAC_BITS = 28;
	localparam int C_W       = 32;
	localparam int Z_W       = 36;
	localparam int OP_W      = 33;
	localparam int LANE_W    = 2 * OP_W - FRAC_BITS;
	localparam int SUM_W     = 42;
	localparam int IDX_W     = 20;
	localparam int CNT_W     = 10;
	localparam int VAL_W     = 32;
	localparam int STEP_W    = 31;
	localparam int CSTEP_W   = 24;
	localparam int COORD_W   = 10;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_LANES = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP      = 3'd4;

	localparam logic signed [C_W-1:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [C_W-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [Z_W-1:0] Z_MAX = 36'sh7_FFFF_FFFF;
	localparam logic signed [Z_W-1:0] Z_MIN = 36'sh8_0000_0000;
	// 2.0 and -2.0 in Q8.28: the escape bound on a single component.
	localparam logic signed [Z_W-1:0] Z_TWO     = 36'sh0_2000_0000;
	localparam logic signed [Z_W-1:0] Z_NEG_TWO = 36'shF_E000_0000;
	// 4.0 in Q28 at the width of a sum of two squares.
	localparam logic signed [OP_W:0]  SQ_FOUR   = 34'sh4000_0000;

	typedef logic signed [OP_W-1:0]   op_t;
	typedef logic signed [LANE_W-1:0] lane_t;

	typedef struct packed {
		logic [IDX_W-1:0]        pixel_index;
		logic signed [C_W-1:0]   c_re;
		logic signed [C_W-1:0]   c_im;
	} job_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [CNT_W-1:0] iteration_count;
		logic             reached_limit;
		logic [VAL_W-1:0] pixel_value;
	} result_t;

endpackage

[hw/rtl/mb5_fifo.sv]
// Small register queue with show-ahead read, used between the stages of the unit.
module mb5_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/mb5_front.sv]
// Front end: takes pixel coordinates and forms the complex constant and image address.
module mb5_front #(
	parameter int IMAGE_SIDE = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic [mb5_pkg::COORD_W-1:0]          pixel_x,
	input  logic [mb5_pkg::COORD_W-1:0]          pixel_y,
	output logic                                 full,
	input  logic signed [mb5_pkg::C_W-1:0]       origin_real,
	input  logic signed [mb5_pkg::C_W-1:0]       origin_imag,
	input  logic [mb5_pkg::STEP_W-1:0]           pixel_step,
	output logic                                 job_wr,
	output mb5_pkg::job_t                        job,
	input  logic                                 job_full
);

	localparam int PROD_W = mb5_pkg::COORD_W + mb5_pkg::STEP_W;
	localparam int CSUM_W = PROD_W + 2;

	logic                          valid_q;
	logic [mb5_pkg::COORD_W-1:0]   x_s1;
	logic [mb5_pkg::COORD_W-1:0]   y_s1;
	logic                          load;
	logic [PROD_W-1:0]             off_re;
	logic [PROD_W-1:0]             off_im;
	logic signed [CSUM_W-1:0]      sum_re;
	logic signed [CSUM_W-1:0]      sum_im;
	logic [31:0]                   idx_wide;

	function automatic logic signed [mb5_pkg::C_W-1:0] sat_c(input logic signed [CSUM_W-1:0] v);
		logic signed [mb5_pkg::C_W-1:0] r;
		if (v > CSUM_W'(mb5_pkg::C_MAX)) begin
			r = mb5_pkg::C_MAX;
		end else if (v < CSUM_W'(mb5_pkg::C_MIN)) begin
			r = mb5_pkg::C_MIN;
		end else begin
			r = v[mb5_pkg::C_W-1:0];
		end
		return r;
	endfunction

	assign full = valid_q && job_full;
	assign load = push && !full;

	assign off_re   = PROD_W'(x_s1) * PROD_W'(pixel_step);
	assign off_im   = PROD_W'(y_s1) * PROD_W'(pixel_step);
	assign sum_re   = CSUM_W'(origin_real) + $signed({2'b00, off_re});
	assign sum_im   = CSUM_W'(origin_imag) + $signed({2'b00, off_im});
	assign idx_wide = 32'(y_s1) * 32'(IMAGE_SIDE) + 32'(x_s1);

	assign job_wr           = valid_q;
	assign job.pixel_index  = idx_wide[mb5_pkg::IDX_W-1:0];
	assign job.c_re         = sat_c(sum_re);
	assign job.c_im         = sat_c(sum_im);

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (valid_q && !job_full) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[hw/rtl/mb5_core.sv]
// Back end: iterates z = z^5 + c on six shared multiplier lanes and builds the result.
`include "assert_macros.svh"

module mb5_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_empty,
	input  mb5_pkg::job_t                     job,
	output logic                              job_pop,
	input  logic [mb5_pkg::CNT_W-1:0]         iteration_limit,
	input  logic [mb5_pkg::CSTEP_W-1:0]       color_step,
	input  logic                              res_full,
	output logic                              res_wr,
	output mb5_pkg::result_t                  res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SQR   = 3'd1;
	localparam logic [2:0] ST_POW   = 3'd2;
	localparam logic [2:0] ST_CROSS = 3'd3;
	localparam logic [2:0] ST_SUM   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam int OP_W   = mb5_pkg::OP_W;
	localparam int SUM_W  = mb5_pkg::SUM_W;
	localparam int Z_W    = mb5_pkg::Z_W;
	localparam int NL     = mb5_pkg::NUM_LANES;
	localparam int VPROD_W = mb5_pkg::CNT_W + mb5_pkg::CSTEP_W;

	logic [2:0]                         state_q;
	logic [mb5_pkg::CNT_W-1:0]          count_q;
	logic [mb5_pkg::IDX_W-1:0]          idx_q;
	logic signed [mb5_pkg::C_W-1:0]     c_re_q;
	logic signed [mb5_pkg::C_W-1:0]     c_im_q;
	logic signed [Z_W-1:0]              zr_q;
	logic signed [Z_W-1:0]              zi_q;
	mb5_pkg::op_t                       r2_q, i2_q, r3_q, i3_q, r4_q, i4_q;
	mb5_pkg::lane_t                     cross_q [NL];

	mb5_pkg::op_t                       op_a [NL];
	mb5_pkg::op_t                       op_b [NL];
	logic signed [2*OP_W-1:0]           prod [NL];
	mb5_pkg::lane_t                     lane_res [NL];

	mb5_pkg::op_t                       zr_op;
	mb5_pkg::op_t                       zi_op;
	logic                               mag_ok;
	logic signed [OP_W:0]               sq_sum;
	logic                               go_on;
	logic signed [SUM_W-1:0]            nr;
	logic signed [SUM_W-1:0]            ni;
	logic                               at_limit;
	logic [VPROD_W-1:0]                 vprod;

	function automatic logic signed [SUM_W-1:0] ext(input mb5_pkg::lane_t v);
		return SUM_W'(v);
	endfunction

	function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
		logic signed [Z_W-1:0] r;
		if (v > SUM_W'(mb5_pkg::Z_MAX)) begin
			r = mb5_pkg::Z_MAX;
		end else if (v < SUM_W'(mb5_pkg::Z_MIN)) begin
			r = mb5_pkg::Z_MIN;
		end else begin
			r = v[Z_W-1:0];
		end
		return r;
	endfunction

	// Operands are narrowed to the operand width (OP_W); while a component is at or beyond
	// magnitude two its products are never used.
	assign zr_op = $signed(zr_q[OP_W-1:0]);
	assign zi_op = $signed(zi_q[OP_W-1:0]);

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			op_a[k] = '0;
			op_b[k] = '0;
		end
		case (state_q)
			ST_SQR: begin
				op_a[0] = zr_op; op_b[0] = zr_op;
				op_a[1] = zi_op; op_b[1] = zi_op;
			end
			ST_POW: begin
				op_a[0] = r2_q;  op_b[0] = zr_op;
				op_a[1] = i2_q;  op_b[1] = zi_op;
				op_a[2] = r2_q;  op_b[2] = r2_q;
				op_a[3] = i2_q;  op_b[3] = i2_q;
			end
			ST_CROSS: begin
				op_a[0] = r4_q;  op_b[0] = zr_op;
				op_a[1] = i4_q;  op_b[1] = zi_op;
				op_a[2] = r3_q;  op_b[2] = i2_q;
				op_a[3] = zr_op; op_b[3] = i4_q;
				op_a[4] = r4_q;  op_b[4] = zi_op;
				op_a[5] = r2_q;  op_b[5] = i3_q;
			end
			default: begin
			end
		endcase
		// Arithmetic shift of the exact product floors it back to Q28.
		for (int k = 0; k < NL; k++) begin
			prod[k]     = op_a[k] * op_b[k];
			lane_res[k] = prod[k][2*OP_W-1:mb5_pkg::FRAC_BITS];
		end
	end

	assign mag_ok = (zr_q < mb5_pkg::Z_TWO) && (zr_q > mb5_pkg::Z_NEG_TWO) &&
		(zi_q < mb5_pkg::Z_TWO) && (zi_q > mb5_pkg::Z_NEG_TWO);
	assign sq_sum = (OP_W + 1)'(r2_q) + (OP_W + 1)'(i2_q);
	assign go_on  = (count_q < iteration_limit) && mag_ok && (sq_sum < mb5_pkg::SQ_FOUR);

	// cross_q: 0 r^5, 1 i^5, 2 r^3 i^2, 3 r i^4, 4 r^4 i, 5 r^2 i^3
	assign nr = ext(cross_q[0]) - ((ext(cross_q[2]) <<< 3) + (ext(cross_q[2]) <<< 1))
		+ ((ext(cross_q[3]) <<< 2) + ext(cross_q[3])) + SUM_W'(c_re_q);
	assign ni = ((ext(cross_q[4]) <<< 2) + ext(cross_q[4]))
		- ((ext(cross_q[5]) <<< 3) + (ext(cross_q[5]) <<< 1))
		+ ext(cross_q[1]) + SUM_W'(c_im_q);

	assign at_limit = (count_q == iteration_limit);
	assign vprod    = VPROD_W'(count_q) * VPROD_W'(color_step);

	assign job_pop             = (state_q == ST_IDLE) && !job_empty;
	assign res_wr              = (state_q == ST_DONE) && !res_full;
	assign res.pixel_index     = idx_q;
	assign res.iteration_count = count_q;
	assign res.reached_limit   = at_limit;
	assign res.pixel_value     = at_limit ? '0 :
		((|vprod[VPROD_W-1:mb5_pkg::VAL_W]) ? '1 : vprod[mb5_pkg::VAL_W-1:0]);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q  <= job.pixel_index;
				c_re_q <= job.c_re;
				c_im_q <= job.c_im;
				zr_q   <= '0;
				zi_q   <= '0;
			end
			ST_SQR: begin
				r2_q <= $signed(lane_res[0][OP_W-1:0]);
				i2_q <= $signed(lane_res[1][OP_W-1:0]);
			end
			ST_POW: begin
				r3_q <= $signed(lane_res[0][OP_W-1:0]);
				i3_q <= $signed(lane_res[1][OP_W-1:0]);
				r4_q <= $signed(lane_res[2][OP_W-1:0]);
				i4_q <= $signed(lane_res[3][OP_W-1:0]);
			end
			ST_CROSS: begin
				for (int k = 0; k < NL; k++) begin
					cross_q[k] <= lane_res[k];
				end
			end
			ST_SUM: begin
				zr_q <= sat_z(nr);
				zi_q <= sat_z(ni);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						count_q <= '0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					state_q <= ST_POW;
				end
				ST_POW: begin
					state_q <= go_on ? ST_CROSS : ST_DONE;
				end
				ST_CROSS: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_SQR;
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMP(a_count_within_limit, state_q != ST_IDLE, count_q <= iteration_limit)
	`ASSERT_NEXT(a_pop_starts_fresh, job_pop, state_q == ST_SQR && count_q == '0)
	`ASSERT_IMP(a_cross_z_bounded, state_q == ST_CROSS, mag_ok)
	`ASSERT_NEXT(a_sum_counts_once, state_q == ST_SUM, count_q == $past(count_q) + 1'b1)

endmodule

[hw/rtl/multibrot_degree5_escape_time_unit.sv]
// Top level of the degree-5 multibrot escape-time unit: configuration registers and queues.
// Each pushed pixel (pixel_x, pixel_y) yields one result: the image address, the number of
// iterations of z = z^5 + c done before |z|^2 reached 4 or the iteration limit was hit, a
// limit flag and a color value. The front end registers the coordinates, forms c and queues
// it; the back end runs one pixel at a time through a sequencer that shares six multiplier
// lanes, and steps through squares, higher powers, cross terms and sum for each iteration;
// the iteration limit defaults to 50. Results wait in an output queue, so new pixels keep
// flowing while the consumer stalls, until the queues fill. Configuration is written
// through cfg_valid/cfg_ready at cfg_index 0 origin_real, 1 origin_imag, 2 pixel_step,
// 3 iteration_limit, 4 color_step; the user must write it only while no pixel is in
// flight, which the block itself does not enforce.
module multibrot_degree5_escape_time_unit #(
	parameter int IMAGE_SIDE = 1024,
	parameter int JOB_DEPTH  = 2,
	parameter int RES_DEPTH  = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [mb5_pkg::COORD_W-1:0]        pixel_x,
	input  logic [mb5_pkg::COORD_W-1:0]        pixel_y,
	output logic                               empty,
	input  logic                               pop,
	output logic [mb5_pkg::IDX_W-1:0]          pixel_index,
	output logic [mb5_pkg::CNT_W-1:0]          iteration_count,
	output logic                               reached_limit,
	output logic [mb5_pkg::VAL_W-1:0]          pixel_value,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mb5_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                        cfg_data
);

	logic signed [mb5_pkg::C_W-1:0]  origin_real_q;
	logic signed [mb5_pkg::C_W-1:0]  origin_imag_q;
	logic [mb5_pkg::STEP_W-1:0]      pixel_step_q;
	logic [mb5_pkg::CNT_W-1:0]       iteration_limit_q;
	logic [mb5_pkg::CSTEP_W-1:0]     color_step_q;

	logic                            job_wr;
	logic                            job_full;
	mb5_pkg::job_t                   job_in;
	logic [$bits(mb5_pkg::job_t)-1:0] job_rd_data;
	mb5_pkg::job_t                   job_out;
	logic                            job_empty;
	logic                            job_pop;
	logic                            res_wr;
	logic                            res_full;
	mb5_pkg::result_t                res_in;
	logic [$bits(mb5_pkg::result_t)-1:0] res_rd_data;
	mb5_pkg::result_t                res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q     <= -32'sd510027366;
			origin_imag_q     <= -32'sd402653184;
			pixel_step_q      <= 31'd894785;
			iteration_limit_q <= 10'd50;
			color_step_q      <= 24'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mb5_pkg::REG_ORIGIN_REAL:     origin_real_q     <= $signed(cfg_data);
				mb5_pkg::REG_ORIGIN_IMAG:     origin_imag_q     <= $signed(cfg_data);
				mb5_pkg::REG_PIXEL_STEP:      pixel_step_q      <= cfg_data[mb5_pkg::STEP_W-1:0];
				mb5_pkg::REG_ITERATION_LIMIT: iteration_limit_q <= cfg_data[mb5_pkg::CNT_W-1:0];
				mb5_pkg::REG_COLOR_STEP:      color_step_q      <= cfg_data[mb5_pkg::CSTEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mb5_front #(
		.IMAGE_SIDE(IMAGE_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.full       (full),
		.origin_real(origin_real_q),
		.origin_imag(origin_imag_q),
		.pixel_step (pixel_step_q),
		.job_wr     (job_wr),
		.job        (job_in),
		.job_full   (job_full)
	);

	mb5_fifo #(
		.WIDTH($bits(mb5_pkg::job_t)),
		.DEPTH(JOB_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_wr),
		.wr_data(job_in),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_data(job_rd_data),
		.empty  (job_empty)
	);

	assign job_out = mb5_pkg::job_t'(job_rd_data);

	mb5_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_empty      (job_empty),
		.job            (job_out),
		.job_pop        (job_pop),
		.iteration_limit(iteration_limit_q),
		.color_step     (color_step_q),
		.res_full       (res_full),
		.res_wr         (res_wr),
		.res            (res_in)
	);

	mb5_fifo #(
		.WIDTH($bits(mb5_pkg::result_t)),
		.DEPTH(RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_wr),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_rd_data),
		.empty  (empty)
	);

	assign res_out         = mb5_pkg::result_t'(res_rd_data);
	assign pixel_index     = res_out.pixel_index;
	assign iteration_count = res_out.iteration_count;
	assign reached_limit   = res_out.reached_limit;
	assign pixel_value     = res_out.pixel_value;

endmodule
